// ===== sv/ggc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the greedy graph coloring block.
// No dependencies; every other file imports this package.
package ggc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int HW_CAP           = 16;
  localparam int ROW_IDX_W        = 4;
  localparam int ROW_W            = 16;
  localparam int COUNT_W          = 5;
  localparam int VERTEX_W         = 4;
  localparam int COLOR_W          = 5;
  localparam int ADDR_W           = 2;
  localparam int DATA_W           = 32;

  localparam logic [ADDR_W-1:0]  ADDR_VERTEX_COUNT = 2'd0;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST  = 5'd16;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_bits;
  } ggc_in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } ggc_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic deg_rd;
    logic deg_wr;
    logic round_start;
    logic pick_step;
    logic emit_pick;
    logic prow_load;
    logic scan_skip;
    logic cand_rd;
    logic cand_drop;
    logic cand_emit;
  } ggc_cmd_t;

  typedef struct packed {
    logic final_row;
    logic idx_last;
    logic scan_last;
    logic scan_skip;
    logic clash;
    logic out_free;
    logic pick_all;
    logic cand_all;
  } ggc_status_t;

endpackage

// ===== sv/ggc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the coloring block: load, degree pass, pick and scan rounds.
// Depends on ggc_pkg for the command and status structs.
module ggc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                row_valid,
  output logic                row_ready,
  input  ggc_pkg::ggc_status_t status,
  output ggc_pkg::ggc_cmd_t    cmd
);
  import ggc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEG_RD = 9'b000000010,
    S_DEG_WR = 9'b000000100,
    S_ROUND  = 9'b000001000,
    S_PICK   = 9'b000010000,
    S_EMIT   = 9'b000100000,
    S_PROW   = 9'b001000000,
    S_SCAN   = 9'b010000000,
    S_CAND   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign row_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = row_valid;
        if (row_valid && status.final_row) begin
          cmd.start  = 1'b1;
          state_next = S_DEG_RD;
        end
      end
      S_DEG_RD: begin
        cmd.deg_rd = 1'b1;
        state_next = S_DEG_WR;
      end
      S_DEG_WR: begin
        cmd.deg_wr = 1'b1;
        state_next = status.idx_last ? S_ROUND : S_DEG_RD;
      end
      S_ROUND: begin
        cmd.round_start = 1'b1;
        state_next      = S_PICK;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (status.idx_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_pick = 1'b1;
          state_next    = status.pick_all ? S_IDLE : S_PROW;
        end
      end
      S_PROW: begin
        cmd.prow_load = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_skip) begin
          cmd.scan_skip = 1'b1;
          if (status.scan_last) state_next = S_ROUND;
        end else begin
          cmd.cand_rd = 1'b1;
          state_next  = S_CAND;
        end
      end
      S_CAND: begin
        if (status.clash) begin
          cmd.cand_drop = 1'b1;
          state_next    = status.scan_last ? S_ROUND : S_SCAN;
        end else if (status.out_free) begin
          cmd.cand_emit = 1'b1;
          if (status.cand_all)       state_next = S_IDLE;
          else if (status.scan_last) state_next = S_ROUND;
          else                       state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/ggc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: adjacency memory, degree table, masks, counters, result register.
// Depends on ggc_pkg; driven by ggc_ctrl through command and status structs.
module ggc_datapath #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ggc_pkg::COUNT_W-1:0]   vertex_count,
  input  ggc_pkg::ggc_in_t              row_word,
  input  ggc_pkg::ggc_cmd_t             cmd,
  output ggc_pkg::ggc_status_t          status,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ggc_pkg::ggc_out_t             res_word
);
  import ggc_pkg::*;

  localparam int LIMIT = (MAX_VERTICES < HW_CAP) ? MAX_VERTICES : HW_CAP;
  localparam int IW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int CW    = $clog2(LIMIT + 1);

  logic [LIMIT-1:0] adj_mem [LIMIT];
  logic [LIMIT-1:0] rd_data;
  logic [CW-1:0]    degree [LIMIT];

  logic [IW-1:0]      i_cnt, e_cnt, pick;
  logic [CW-1:0]      best_deg;
  logic               found;
  logic [LIMIT-1:0]   done_mask, round_mask, pick_row;
  logic [COLOR_W-1:0] round;

  logic [CW-1:0]    n_used;
  logic [IW-1:0]    nm1;
  logic [LIMIT-1:0] vmask, pick_bit, cand_bit;
  logic             row_ok, rd_en, better;
  logic [IW-1:0]    rd_addr;
  logic [CW-1:0]    deg_i;

  always_comb begin
    if (vertex_count == '0)                    n_used = CW'(1);
    else if (vertex_count > COUNT_W'(LIMIT))   n_used = CW'(LIMIT);
    else                                       n_used = CW'(vertex_count);
    for (int j = 0; j < LIMIT; j++) vmask[j] = (CW'(j) < n_used);
  end

  assign nm1      = IW'(n_used - 1'b1);
  assign row_ok   = (COUNT_W'(row_word.row_index) < COUNT_W'(n_used));
  assign pick_bit = {{(LIMIT-1){1'b0}}, 1'b1} << pick;
  assign cand_bit = {{(LIMIT-1){1'b0}}, 1'b1} << e_cnt;
  assign deg_i    = degree[i_cnt];
  assign better   = !done_mask[i_cnt] && (!found || (deg_i > best_deg));

  assign rd_en   = cmd.deg_rd | cmd.emit_pick | cmd.cand_rd;
  assign rd_addr = cmd.emit_pick ? pick : (cmd.cand_rd ? e_cnt : i_cnt);

  assign status.final_row = row_ok &&
      (COUNT_W'(row_word.row_index) == COUNT_W'(n_used) - COUNT_W'(1));
  assign status.idx_last  = (i_cnt == nm1);
  assign status.scan_last = (e_cnt == nm1);
  assign status.scan_skip = done_mask[e_cnt] | pick_row[e_cnt];
  assign status.clash     = |(rd_data & round_mask & vmask);
  assign status.out_free  = !res_valid || res_ready;
  assign status.pick_all  = (((done_mask | pick_bit) & vmask) == vmask);
  assign status.cand_all  = (((done_mask | cand_bit) & vmask) == vmask);

  // adjacency store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      adj_mem[row_word.row_index[IW-1:0]] <= row_word.row_bits[LIMIT-1:0];
    end
    if (rd_en) begin
      rd_data <= adj_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      done_mask <= '0;
      round     <= '0;
      i_cnt     <= '0;
    end
    if (cmd.deg_wr) begin
      degree[i_cnt] <= CW'($countones(rd_data & vmask));
      i_cnt         <= i_cnt + 1'b1;
    end
    if (cmd.round_start) begin
      round      <= round + 1'b1;
      round_mask <= '0;
      found      <= 1'b0;
      i_cnt      <= '0;
    end
    if (cmd.pick_step) begin
      if (better) begin
        pick     <= i_cnt;
        best_deg <= deg_i;
        found    <= 1'b1;
      end
      i_cnt <= i_cnt + 1'b1;
    end
    if (cmd.emit_pick) begin
      done_mask  <= done_mask | pick_bit;
      round_mask <= round_mask | pick_bit;
    end
    if (cmd.prow_load) begin
      pick_row <= rd_data;
      e_cnt    <= '0;
    end
    if (cmd.scan_skip || cmd.cand_drop) begin
      e_cnt <= e_cnt + 1'b1;
    end
    if (cmd.cand_emit) begin
      done_mask  <= done_mask | cand_bit;
      round_mask <= round_mask | cand_bit;
      e_cnt      <= e_cnt + 1'b1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_pick || cmd.cand_emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pick) begin
      res_word.vertex <= VERTEX_W'(pick);
      res_word.color  <= round;
      res_word.last   <= status.pick_all;
    end else if (cmd.cand_emit) begin
      res_word.vertex <= VERTEX_W'(e_cnt);
      res_word.color  <= round;
      res_word.last   <= status.cand_all;
    end
  end

endmodule

// ===== sv/greedy_graph_coloring_top.sv =====
`timescale 1ns / 1ps
// Top level of the greedy graph coloring block: APB register and the two halves.
// Depends on ggc_pkg, ggc_ctrl and ggc_datapath.
//
// Rows are taken one word per cycle while the block is idle; a row whose index is
// not below the vertex count N is dropped. The row of vertex N-1 starts a run that
// holds the row channel off until the last result is handed to the output
// register: a degree pass reads each row and counts its degree, then each round
// picks the top-degree uncolored vertex and checks the remaining vertices against
// those already given that round's color; output stalls hold the run. The run
// time is set by the single read port of the adjacency memory, which every degree
// count and every candidate check goes through, one row per access.
module greedy_graph_coloring_top #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        row_valid,
  output logic                        row_ready,
  input  ggc_pkg::ggc_in_t            row_word,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ggc_pkg::ggc_out_t           res_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ggc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ggc_pkg::DATA_W-1:0]  pwdata,
  output logic [ggc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ggc_pkg::*;

  logic [COUNT_W-1:0] vertex_count;
  ggc_cmd_t           cmd;
  ggc_status_t        status;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VERTEX_COUNT) ? DATA_W'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT)) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  ggc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ggc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .row_word     (row_word),
    .cmd          (cmd),
    .status       (status),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_word     (res_word)
  );

endmodule
